// ----- sv/ths_pkg.sv -----
// Shared types, codes and constants of the timer heap scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ths_pkg;

  localparam int HANDLE_W    = 6;
  localparam int TIME_W      = 32;
  localparam int MAX_RESULTS = 63;

  localparam logic [1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [1:0] MODE_CANCEL   = 2'd1;
  localparam logic [1:0] MODE_RESTART  = 2'd2;
  localparam logic [1:0] MODE_POLL     = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd2;
  localparam logic [2:0] ST_EXPIRED    = 3'd3;
  localparam logic [2:0] ST_NONE       = 3'd4;

  typedef struct packed {
    logic [1:0]          mode;
    logic [HANDLE_W-1:0] handle_in;
    logic [TIME_W-1:0]   delay_ms;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic                earliest_changed;
    logic [TIME_W-1:0]   next_wait_ms;
    logic                queue_empty;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [HANDLE_W-1:0] handle;
  } heap_entry_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_DISP,
    OP_CAN1,
    OP_REM0,
    OP_REM1,
    OP_REM2,
    OP_UP_READ,
    OP_UP_MOVE,
    OP_DN_READ1,
    OP_DN_READ2,
    OP_DN_PICK,
    OP_DN_MOVE,
    OP_PLACE,
    OP_SCH0,
    OP_SCH1,
    OP_ROOT_RD,
    OP_ROOT_EV,
    OP_EMIT
  } ctrl_op_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       hit;
    logic       full;
    logic       rm_lt;
    logic       rm_zero;
    logic       slot_zero;
    logic       up_less;
    logic       child_ge;
    logic       child2_in;
    logic       root_exp;
    logic       n_zero;
    logic       last_r;
    logic       out_free;
    logic       sched_started;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- sv/timer_heap_scheduler_unit.sv -----
// Top level of the timer heap scheduler: sequencer plus heap datapath.
// A schedule places the new entry and climbs the heap; a cancel removes the entry on a hit and
// sifts the moved one up or down; a poll removes and reports each expired timer in turn.
// One item is in work at a time; the input stalls until its last result is in the output
// register. Reset (sync, active high) empties the queue at once (flag bits).
`timescale 1ns / 1ps
`default_nettype none
module timer_heap_scheduler_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ths_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ths_pkg::out_item_t      out_item
);

  // commands from the sequencer and flags back from the datapath
  ths_pkg::ctrl_op_t   op;
  ths_pkg::dp_status_t status;

  // the sequencer owns the input handshake; an item is taken only when idle
  ths_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  // the datapath holds the heap, handle map, free list and output register;
  // a result waits there while the sequencer moves on to the next removal
  ths_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (status)
  );

endmodule
`default_nettype wire

// ----- sv/ths_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ths_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/ths_ctrl.sv -----
// Sequencer of the timer heap: steps through schedule, cancel, restart, sift and poll.
`timescale 1ns / 1ps
`default_nettype none
module ths_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ths_pkg::dp_status_t status,
  output ths_pkg::ctrl_op_t        op
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CAN1, S_REM0, S_REM1, S_REM2, S_REM3,
    S_SU0, S_SU1, S_SD0, S_SD1, S_SD2, S_SD3, S_PLACE,
    S_SCH0, S_SCH1, S_RRD, S_REV, S_EMIT
  } state_t;

  state_t state, state_next, cont;

  assign in_stall = (state != S_IDLE);

  // where a finished removal or sift goes on
  always_comb begin
    if (status.mode == ths_pkg::MODE_RESTART && !status.sched_started) begin
      cont = S_SCH0;
    end else begin
      cont = S_RRD;
    end
  end

  always_comb begin
    state_next = state;
    op         = ths_pkg::OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = ths_pkg::OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        op = ths_pkg::OP_DISP;
        priority if (status.mode == ths_pkg::MODE_POLL) begin
          state_next = S_REV;
        end else if (status.mode == ths_pkg::MODE_CANCEL) begin
          state_next = status.hit ? S_CAN1 : S_RRD;
        end else if (status.mode == ths_pkg::MODE_RESTART && status.hit) begin
          state_next = S_CAN1;
        end else begin
          state_next = S_SCH0;
        end
      end
      S_CAN1: begin
        op         = ths_pkg::OP_CAN1;
        state_next = S_REM0;
      end
      S_REM0: begin
        op         = ths_pkg::OP_REM0;
        state_next = S_REM1;
      end
      S_REM1: begin
        op         = ths_pkg::OP_REM1;
        state_next = status.rm_lt ? S_REM2 : cont;
      end
      S_REM2: begin
        op         = ths_pkg::OP_REM2;
        state_next = status.rm_zero ? S_SD0 : S_REM3;
      end
      S_REM3: begin
        op         = ths_pkg::OP_UP_MOVE;
        state_next = status.up_less ? S_SU0 : S_SD0;
      end
      S_SU0: begin
        op         = ths_pkg::OP_UP_READ;
        state_next = status.slot_zero ? S_PLACE : S_SU1;
      end
      S_SU1: begin
        op         = ths_pkg::OP_UP_MOVE;
        state_next = status.up_less ? S_SU0 : S_PLACE;
      end
      S_SD0: begin
        op         = ths_pkg::OP_DN_READ1;
        state_next = status.child_ge ? S_PLACE : S_SD1;
      end
      S_SD1: begin
        op         = ths_pkg::OP_DN_READ2;
        state_next = status.child2_in ? S_SD2 : S_SD3;
      end
      S_SD2: begin
        op         = ths_pkg::OP_DN_PICK;
        state_next = S_SD3;
      end
      S_SD3: begin
        op         = ths_pkg::OP_DN_MOVE;
        state_next = status.up_less ? S_SD0 : S_PLACE;
      end
      S_PLACE: begin
        op         = ths_pkg::OP_PLACE;
        state_next = cont;
      end
      S_SCH0: begin
        op         = ths_pkg::OP_SCH0;
        state_next = status.full ? S_RRD : S_SCH1;
      end
      S_SCH1: begin
        op         = ths_pkg::OP_SCH1;
        state_next = S_SU0;
      end
      S_RRD: begin
        op         = ths_pkg::OP_ROOT_RD;
        state_next = S_REV;
      end
      S_REV: begin
        op = ths_pkg::OP_ROOT_EV;
        if (status.mode == ths_pkg::MODE_POLL && status.n_zero && status.root_exp) begin
          state_next = S_REM0;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        op = ths_pkg::OP_EMIT;
        if (status.out_free) begin
          if (status.mode == ths_pkg::MODE_POLL && !status.last_r) begin
            state_next = S_REM0;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ths_datapath.sv -----
// Heap, handle and free-list storage of the timer heap with its working registers.
`timescale 1ns / 1ps
`default_nettype none
module ths_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ths_pkg::ctrl_op_t op,
  input  wire ths_pkg::in_item_t in_item,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output ths_pkg::out_item_t     out_item,
  output ths_pkg::dp_status_t    status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;

  // working registers
  logic [1:0]                    mode;
  logic [ths_pkg::HANDLE_W-1:0]  hin;
  logic [ths_pkg::TIME_W-1:0]    now;
  logic [ths_pkg::TIME_W-1:0]    sched_e;
  logic [AW-1:0]                 free_head;
  logic [AW-1:0]                 count;
  logic [CAPACITY-1:0]           active;
  logic [CAPACITY-1:0]           free_wr;
  logic [AW-1:0]                 rm_slot;
  logic [AW-1:0]                 rm_h;
  logic [AW-1:0]                 slot;
  logic [AW-1:0]                 cidx;
  ths_pkg::heap_entry_t          key;
  ths_pkg::heap_entry_t          cand;
  logic [5:0]                    n;
  logic                          sched_started;
  logic                          last_r;
  logic [2:0]                    res_status;
  logic [ths_pkg::HANDLE_W-1:0]  res_handle;
  logic                          res_chg;
  logic [ths_pkg::TIME_W-1:0]    res_wait;
  logic                          res_empty;

  // memory ports
  logic                 heap_we;
  logic [AW-1:0]        heap_waddr;
  ths_pkg::heap_entry_t heap_wdata;
  logic [AW-1:0]        heap_raddr;
  ths_pkg::heap_entry_t heap_rdata;
  logic                 slot_we;
  logic [AW-1:0]        slot_waddr;
  logic [AW-1:0]        slot_rdata;
  logic                 free_we;
  logic [AW-1:0]        free_rdata;

  logic [AW-1:0]        hin_idx;
  logic [AW-1:0]        par;
  logic [AW-1:0]        par_rm;
  logic [CW-1:0]        child;
  logic [CW-1:0]        child2;
  logic [CW-1:0]        cnt_ext;
  logic                 hit;
  logic                 full;
  logic                 up_less;
  logic                 down_less;
  logic                 root_exp;
  logic                 out_free;
  logic [32:0]          sum;

  function automatic logic [AW-1:0] free_rst(input logic [AW-1:0] h);
    if (h == AW'(CAPACITY - 1)) begin
      return '0;
    end
    return h + AW'(1);
  endfunction

  assign hin_idx  = hin[AW-1:0];
  assign par      = AW'((slot - AW'(1)) >> 1);
  assign par_rm   = AW'((rm_slot - AW'(1)) >> 1);
  assign child    = {slot, 1'b1};
  assign child2   = {slot, 1'b1} + CW'(1);
  assign cnt_ext  = {1'b0, count};
  assign hit      = (hin != '0) && ({1'b0, hin} < 7'(CAPACITY)) && active[hin_idx];
  assign full     = (free_head == '0) || (count >= AW'(CAPACITY - 1));
  assign up_less  = key.expiry < heap_rdata.expiry;
  assign down_less = cand.expiry < key.expiry;
  assign root_exp = (count != '0) && (heap_rdata.expiry <= now)
                    && (n < 6'(ths_pkg::MAX_RESULTS));
  assign out_free = !out_valid || !out_stall;
  assign sum      = {1'b0, in_item.now_ms} + {1'b0, in_item.delay_ms};

  always_comb begin
    status.mode          = mode;
    status.hit           = hit;
    status.full          = full;
    status.rm_lt         = rm_slot < count;
    status.rm_zero       = rm_slot == '0;
    status.slot_zero     = slot == '0;
    status.up_less       = (op == ths_pkg::OP_DN_MOVE) ? down_less : up_less;
    status.child_ge      = child >= cnt_ext;
    status.child2_in     = child2 < cnt_ext;
    status.root_exp      = root_exp;
    status.n_zero        = n == '0;
    status.last_r        = last_r;
    status.out_free      = out_free;
    status.sched_started = sched_started;
  end

  // heap read address by step
  always_comb begin
    unique case (op)
      ths_pkg::OP_REM1:     heap_raddr = count;
      ths_pkg::OP_REM2:     heap_raddr = par_rm;
      ths_pkg::OP_UP_READ:  heap_raddr = par;
      ths_pkg::OP_DN_READ1: heap_raddr = child[AW-1:0];
      ths_pkg::OP_DN_READ2: heap_raddr = child2[AW-1:0];
      default:              heap_raddr = '0;
    endcase
  end

  // heap and slot writes: move a parent down, a child up, or place the key
  always_comb begin
    heap_we    = 1'b0;
    heap_wdata = key;
    unique case (op)
      ths_pkg::OP_UP_MOVE: begin
        heap_we    = up_less;
        heap_wdata = heap_rdata;
      end
      ths_pkg::OP_DN_MOVE: begin
        heap_we    = down_less;
        heap_wdata = cand;
      end
      ths_pkg::OP_PLACE: heap_we = 1'b1;
      default: heap_we = 1'b0;
    endcase
    heap_waddr = slot;
    slot_we    = heap_we;
    slot_waddr = heap_wdata.handle[AW-1:0];
  end

  assign free_we = (op == ths_pkg::OP_REM0);

  ths_ram #(.WIDTH($bits(ths_pkg::heap_entry_t)), .DEPTH(CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  ths_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot),
    .raddr (hin_idx),
    .rdata (slot_rdata)
  );

  ths_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (rm_h),
    .wdata (free_head),
    .raddr (free_head),
    .rdata (free_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= AW'(1);
      count     <= '0;
      active    <= '0;
      free_wr   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (op)
        ths_pkg::OP_REM0: begin
          free_head     <= rm_h;
          free_wr[rm_h] <= 1'b1;
          active[rm_h]  <= 1'b0;
          count         <= count - AW'(1);
        end
        ths_pkg::OP_SCH1: begin
          free_head <= free_wr[free_head] ? free_rdata : free_rst(free_head);
          count     <= count + AW'(1);
        end
        ths_pkg::OP_PLACE: active[key.handle[AW-1:0]] <= 1'b1;
        default: ;
      endcase
      if (op == ths_pkg::OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    unique case (op)
      ths_pkg::OP_LATCH: begin
        mode          <= in_item.mode;
        hin           <= in_item.handle_in;
        now           <= in_item.now_ms;
        sched_e       <= sum[32] ? '1 : sum[31:0];
        n             <= '0;
        sched_started <= 1'b0;
      end
      ths_pkg::OP_DISP: begin
        res_chg <= 1'b0;
        if (mode == ths_pkg::MODE_POLL) begin
          res_status <= ths_pkg::ST_NONE;
          res_handle <= '0;
        end else begin
          res_status <= hit ? ths_pkg::ST_OK : ths_pkg::ST_NOT_ACTIVE;
          res_handle <= hit ? hin : '0;
        end
      end
      ths_pkg::OP_CAN1: begin
        rm_slot <= slot_rdata;
        rm_h    <= hin_idx;
      end
      ths_pkg::OP_REM2: begin
        key  <= heap_rdata;
        slot <= rm_slot;
      end
      ths_pkg::OP_UP_MOVE: begin
        if (up_less) begin
          slot <= par;
        end
      end
      ths_pkg::OP_DN_READ2: begin
        cand <= heap_rdata;
        cidx <= child[AW-1:0];
      end
      ths_pkg::OP_DN_PICK: begin
        if (heap_rdata.expiry < cand.expiry) begin
          cand <= heap_rdata;
          cidx <= child2[AW-1:0];
        end
      end
      ths_pkg::OP_DN_MOVE: begin
        if (down_less) begin
          slot <= cidx;
        end
      end
      ths_pkg::OP_SCH0: begin
        sched_started <= 1'b1;
        if (full) begin
          res_status <= ths_pkg::ST_FULL;
          res_handle <= '0;
          res_chg    <= 1'b0;
        end
      end
      ths_pkg::OP_SCH1: begin
        key.expiry <= sched_e;
        key.handle <= ths_pkg::HANDLE_W'(free_head);
        slot       <= count;
        res_status <= ths_pkg::ST_OK;
        res_handle <= ths_pkg::HANDLE_W'(free_head);
        res_chg    <= (count == '0) || (sched_e < heap_rdata.expiry);
      end
      ths_pkg::OP_ROOT_EV: begin
        res_empty <= count == '0;
        if (count == '0) begin
          res_wait <= '1;
        end else if (heap_rdata.expiry > now) begin
          res_wait <= heap_rdata.expiry - now;
        end else begin
          res_wait <= '0;
        end
        rm_slot <= '0;
        rm_h    <= heap_rdata.handle[AW-1:0];
        if (mode == ths_pkg::MODE_POLL) begin
          if (n == '0) begin
            last_r <= !root_exp;
            if (root_exp) begin
              res_status <= ths_pkg::ST_EXPIRED;
              res_handle <= heap_rdata.handle;
              n          <= 6'd1;
            end
          end else begin
            last_r <= !root_exp;
          end
        end else begin
          last_r <= 1'b1;
        end
      end
      ths_pkg::OP_EMIT: begin
        if (out_free) begin
          out_item.status           <= res_status;
          out_item.handle_out       <= res_handle;
          out_item.earliest_changed <= res_chg;
          out_item.next_wait_ms     <= res_wait;
          out_item.queue_empty      <= res_empty;
          out_item.last             <= last_r;
          if (mode == ths_pkg::MODE_POLL && !last_r) begin
            res_handle <= ths_pkg::HANDLE_W'(rm_h);
            n          <= n + 6'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // the heap size and the active flags agree once an item's changes are complete
  a_count_matches_active: assert property (@(posedge clk) disable iff (rst)
    (op == ths_pkg::OP_EMIT) |-> ($countones(active) == int'(count)))
    else $error("active handle count out of step with heap size");

  a_free_head_inactive: assert property (@(posedge clk) disable iff (rst)
    !active[free_head])
    else $error("free list head is an active handle");

  a_emit_shows_item: assert property (@(posedge clk) disable iff (rst)
    (op == ths_pkg::OP_EMIT && out_free) |=> out_valid)
    else $error("result item not presented after emit");

endmodule
`default_nettype wire
